@@ design/gaze_smoothed_zoom_crop_top_macros.svh @@
// assertion helpers for the zoom crop block
`ifndef GAZE_SMOOTHED_ZOOM_CROP_TOP_MACROS_SVH
`define GAZE_SMOOTHED_ZOOM_CROP_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GSZC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GSZC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/gszc_pkg.sv @@
`default_nettype none
package gszc_pkg;

	localparam int WINDOW_LEN = 10;

	localparam int GAZE_W   = 13;
	localparam int CROP_W   = 12;
	localparam int CORNER_W = 14;
	localparam int CFG_IDX_W = 4;

	// running window sum and the divide-by-length reciprocal
	localparam int SUM_W    = GAZE_W + $clog2(WINDOW_LEN);
	localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
	localparam int DIV_K    = SUM_W + $clog2(WINDOW_LEN);
	localparam longint AVG_RECIP = ((longint'(1) << DIV_K) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int RECIP_W  = DIV_K - $clog2(WINDOW_LEN) + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;

	// crop size arithmetic
	localparam int MOVE_SPAN = 100;
	localparam int CROP_MAX  = (1 << CROP_W) - 1;
	localparam int MOVE_W    = GAZE_W + 1;
	localparam int NUM_W     = MOVE_W + CROP_W + 3;
	localparam int SAT_N     = (CROP_MAX + 1) * MOVE_SPAN;
	localparam int CLIP_W    = $clog2(SAT_N);
	localparam int SPAN_K    = CLIP_W + $clog2(MOVE_SPAN);
	localparam longint SPAN_RECIP = ((longint'(1) << SPAN_K) + MOVE_SPAN - 1) / MOVE_SPAN;
	localparam int SPAN_RECIP_W = SPAN_K - $clog2(MOVE_SPAN) + 1;
	localparam int SPROD_W   = CLIP_W + SPAN_RECIP_W;

	localparam int MIN_CROP_W_RST = 320;
	localparam int MAX_CROP_W_RST = 640;
	localparam int MIN_CROP_H_RST = 180;
	localparam int MAX_CROP_H_RST = 360;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_CROP_WIDTH  = 4'd0,
		CFG_MAX_CROP_WIDTH  = 4'd1,
		CFG_MIN_CROP_HEIGHT = 4'd2,
		CFG_MAX_CROP_HEIGHT = 4'd3
	} cfg_reg_t;

endpackage
`default_nettype wire

@@ design/gszc_gaze_if.sv @@
`default_nettype none
interface gszc_gaze_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gszc_pkg::GAZE_W-1:0]      gaze_x;
	logic signed [gszc_pkg::GAZE_W-1:0]      gaze_y;

	modport source (output valid, gaze_x, gaze_y, input ready);
	modport sink   (input valid, gaze_x, gaze_y, output ready);
endinterface
`default_nettype wire

@@ design/gszc_result_if.sv @@
`default_nettype none
interface gszc_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gszc_pkg::GAZE_W-1:0]      center_x;
	logic signed [gszc_pkg::GAZE_W-1:0]      center_y;
	logic        [gszc_pkg::CROP_W-1:0]      crop_width;
	logic        [gszc_pkg::CROP_W-1:0]      crop_height;
	logic signed [gszc_pkg::CORNER_W-1:0]    corner_x;
	logic signed [gszc_pkg::CORNER_W-1:0]    corner_y;

	modport source (output valid, center_x, center_y, crop_width, crop_height,
		corner_x, corner_y, input ready);
	modport sink   (input valid, center_x, center_y, crop_width, crop_height,
		corner_x, corner_y, output ready);
endinterface
`default_nettype wire

@@ design/gszc_cfg_if.sv @@
`default_nettype none
interface gszc_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [gszc_pkg::CFG_IDX_W-1:0]          index;
	logic [gszc_pkg::CROP_W-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/gaze_smoothed_zoom_crop_top.sv @@
// six pipeline stages, s1 to s6, each with its own valid and stall; s6 is the output
// register; throughput: one sample per cycle unless all stages are full and the output
// is held, and bubbles close up while the output is held
// the first window-length-minus-one samples after reset give no result
// reset (arst_n, asynchronous) clears the fill count, window sums, previous centre and
// stage valids, and loads the crop size registers with their default values
`default_nettype none
`include "gaze_smoothed_zoom_crop_top_macros.svh"
module gaze_smoothed_zoom_crop_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	gszc_gaze_if.sink         gaze,
	gszc_cfg_if.sink          cfg,
	gszc_result_if.source     result
);

	localparam int GW  = gszc_pkg::GAZE_W;
	localparam int SW  = gszc_pkg::SUM_W;
	localparam int CW  = gszc_pkg::CROP_W;
	localparam int NW  = gszc_pkg::NUM_W;
	localparam int MW  = gszc_pkg::MOVE_W;
	localparam int KW  = gszc_pkg::CORNER_W;
	localparam int LEN = gszc_pkg::WINDOW_LEN;

	// truncating average: magnitude times reciprocal, sign put back after
	function automatic logic signed [GW-1:0] avg_of(input logic signed [SW-1:0] s);
		logic [SW-1:0]                     mag;
		logic [gszc_pkg::PROD_W-1:0]       prod;
		logic [GW-1:0]                     q;
		mag  = s[SW-1] ? SW'(-s) : SW'(s);
		prod = gszc_pkg::PROD_W'(mag) * gszc_pkg::PROD_W'(gszc_pkg::AVG_RECIP);
		q    = prod[gszc_pkg::DIV_K +: GW];
		return s[SW-1] ? $signed(-q) : $signed(q);
	endfunction

	function automatic logic [GW-1:0] abs_diff(input logic signed [GW-1:0] a,
		input logic signed [GW-1:0] b);
		logic signed [GW:0] d;
		d = $signed({a[GW-1], a}) - $signed({b[GW-1], b});
		return d[GW] ? GW'(-d) : GW'(d);
	endfunction

	// numerator of the crop line: move * (min - max) + span * max
	function automatic logic signed [NW-1:0] crop_num(input logic [MW-1:0] mv,
		input logic [CW-1:0] mn, input logic [CW-1:0] mx);
		logic signed [CW:0]   df;
		logic signed [NW-1:0] mv_e, df_e, base;
		df   = $signed({1'b0, mn}) - $signed({1'b0, mx});
		mv_e = $signed(NW'(mv));
		df_e = NW'(df);
		base = $signed(NW'(mx)) * $signed(NW'(gszc_pkg::MOVE_SPAN));
		return mv_e * df_e + base;
	endfunction

	// floor at zero, saturate, else divide by the span via reciprocal
	function automatic logic [CW-1:0] crop_size(input logic signed [NW-1:0] n);
		logic                           sat;
		logic [gszc_pkg::SPROD_W-1:0]   prod;
		sat  = n >= $signed(NW'(gszc_pkg::SAT_N));
		prod = gszc_pkg::SPROD_W'(n[gszc_pkg::CLIP_W-1:0])
			* gszc_pkg::SPROD_W'(gszc_pkg::SPAN_RECIP);
		if (n[NW-1])
			return '0;
		else if (sat)
			return CW'(gszc_pkg::CROP_MAX);
		else
			return prod[gszc_pkg::SPAN_K +: CW];
	endfunction

	// configuration
	logic [CW-1:0] min_w_q, max_w_q, min_h_q, max_h_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w_q <= CW'(gszc_pkg::MIN_CROP_W_RST);
			max_w_q <= CW'(gszc_pkg::MAX_CROP_W_RST);
			min_h_q <= CW'(gszc_pkg::MIN_CROP_H_RST);
			max_h_q <= CW'(gszc_pkg::MAX_CROP_H_RST);
		end else if (cfg.valid) begin
			unique case (gszc_pkg::cfg_reg_t'(cfg.index))
				gszc_pkg::CFG_MIN_CROP_WIDTH:  min_w_q <= cfg.data;
				gszc_pkg::CFG_MAX_CROP_WIDTH:  max_w_q <= cfg.data;
				gszc_pkg::CFG_MIN_CROP_HEIGHT: min_h_q <= cfg.data;
				gszc_pkg::CFG_MAX_CROP_HEIGHT: max_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage valids and per-stage stall chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || result.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign gaze.ready = rdy_s1;

	logic acc;
	assign acc = gaze.valid && rdy_s1;

	// sample window and running sums
	logic signed [GW-1:0]           win_x_q [LEN];
	logic signed [GW-1:0]           win_y_q [LEN];
	logic signed [SW-1:0]           sum_x_q, sum_y_q;
	logic [gszc_pkg::FILL_W-1:0]    fill_q;
	logic                           full, drop_old;
	logic signed [GW-1:0]           old_x, old_y;
	logic signed [SW-1:0]           sum_x_nxt, sum_y_nxt;

	// the oldest entry only counts once the window really holds a full set
	assign drop_old  = fill_q == gszc_pkg::FILL_W'(LEN);
	assign full      = fill_q >= gszc_pkg::FILL_W'(LEN - 1);
	assign old_x     = drop_old ? win_x_q[0] : '0;
	assign old_y     = drop_old ? win_y_q[0] : '0;
	assign sum_x_nxt = sum_x_q - SW'(old_x) + SW'(gaze.gaze_x);
	assign sum_y_nxt = sum_y_q - SW'(old_y) + SW'(gaze.gaze_y);

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < LEN - 1; i++) begin
				win_x_q[i] <= win_x_q[i + 1];
				win_y_q[i] <= win_y_q[i + 1];
			end
			win_x_q[LEN - 1] <= gaze.gaze_x;
			win_y_q[LEN - 1] <= gaze.gaze_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			fill_q  <= '0;
		end else if (acc) begin
			sum_x_q <= sum_x_nxt;
			sum_y_q <= sum_y_nxt;
			if (!drop_old)
				fill_q <= fill_q + 1'b1;
		end
	end

	// pipeline payload
	logic signed [SW-1:0]   sum_x_s1, sum_y_s1;
	logic signed [GW-1:0]   cx_s2, cy_s2, cx_s3, cy_s3, cx_s4, cy_s4, cx_s5, cy_s5;
	logic [MW-1:0]          move_s3;
	logic signed [NW-1:0]   num_w_s4, num_h_s4;
	logic [CW-1:0]          cw_s5, ch_s5;
	logic signed [GW-1:0]   prev_x_q, prev_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (rdy_s1) v_s1 <= acc && full;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			// movement is measured against the last centre that went on to a result
			if (v_s2 && rdy_s3) begin
				prev_x_q <= cx_s2;
				prev_y_q <= cy_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sum_x_s1 <= sum_x_nxt;
			sum_y_s1 <= sum_y_nxt;
		end
		if (rdy_s2) begin
			cx_s2 <= avg_of(sum_x_s1);
			cy_s2 <= avg_of(sum_y_s1);
		end
		if (rdy_s3) begin
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			move_s3 <= MW'(abs_diff(prev_x_q, cx_s2)) + MW'(abs_diff(prev_y_q, cy_s2));
		end
		if (rdy_s4) begin
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			num_w_s4 <= crop_num(move_s3, min_w_q, max_w_q);
			num_h_s4 <= crop_num(move_s3, min_h_q, max_h_q);
		end
		if (rdy_s5) begin
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;
			cw_s5 <= crop_size(num_w_s4);
			ch_s5 <= crop_size(num_h_s4);
		end
		if (rdy_s6) begin
			result.center_x    <= cx_s5;
			result.center_y    <= cy_s5;
			result.crop_width  <= cw_s5;
			result.crop_height <= ch_s5;
			result.corner_x    <= KW'(cx_s5) - $signed(KW'(cw_s5[CW-1:1]));
			result.corner_y    <= KW'(cy_s5) - $signed(KW'(ch_s5[CW-1:1]));
		end
	end

	assign result.valid = v_s6;

	`GSZC_ASSERT_NOW(a_no_early_result, clk, arst_n, result.valid,
		(fill_q >= gszc_pkg::FILL_W'(LEN - 1)), "result before window filled")
	`GSZC_ASSERT_NOW(a_corner_x, clk, arst_n, result.valid,
		(result.corner_x == (KW'(result.center_x) - $signed(KW'(result.crop_width[CW-1:1])))),
		"corner_x inconsistent with centre and width")
	`GSZC_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !gaze.ready,
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !result.ready),
		"input held off with a bubble in the pipeline")

endmodule
`default_nettype wire

@@ tb/gaze_zoom_checker.sv @@
`timescale 1ns / 100ps
module gaze_zoom_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	gszc_gaze_if      gaze,
	gszc_cfg_if       cfg,
	gszc_result_if    result,
	output int        errors,
	output int        pending,
	output int        checked
);

	localparam int GAZE_W     = gszc_pkg::GAZE_W;
	localparam int CROP_W     = gszc_pkg::CROP_W;
	localparam int CORNER_W   = gszc_pkg::CORNER_W;
	localparam int WINDOW_LEN = gszc_pkg::WINDOW_LEN;
	localparam int MOVE_SPAN  = gszc_pkg::MOVE_SPAN;
	localparam int CROP_MAX   = gszc_pkg::CROP_MAX;

	typedef struct packed {
		logic signed [GAZE_W-1:0]   center_x;
		logic signed [GAZE_W-1:0]   center_y;
		logic        [CROP_W-1:0]   crop_width;
		logic        [CROP_W-1:0]   crop_height;
		logic signed [CORNER_W-1:0] corner_x;
		logic signed [CORNER_W-1:0] corner_y;
	} zoom_t;

	logic signed [GAZE_W-1:0] hist_x [WINDOW_LEN];
	logic signed [GAZE_W-1:0] hist_y [WINDOW_LEN];
	int                       filled;
	int                       last_cx;
	int                       last_cy;
	logic [CROP_W-1:0]        min_w, max_w, min_h, max_h;

	zoom_t zoom_expected_q [$];

	// size moves along a line from mx (still) to mn (a move of one span)
	function automatic logic [CROP_W-1:0] crop_len(input int move, input logic [CROP_W-1:0] mn,
			input logic [CROP_W-1:0] mx);
		longint n;
		longint q;
		n = longint'(move) * (longint'(mn) - longint'(mx)) + longint'(MOVE_SPAN) * longint'(mx);
		if (n < 0)
			return '0;
		q = n / MOVE_SPAN;
		if (q > CROP_MAX)
			q = CROP_MAX;
		return q[CROP_W-1:0];
	endfunction

	function automatic bit smooth_gaze_step(input logic signed [GAZE_W-1:0] x,
			input logic signed [GAZE_W-1:0] y, output zoom_t z);
		int i;
		int sx, sy, cx, cy, move, kx, ky;
		logic [CROP_W-1:0] cw, ch;
		for (i = 0; i < WINDOW_LEN - 1; i++) begin
			hist_x[i] = hist_x[i+1];
			hist_y[i] = hist_y[i+1];
		end
		hist_x[WINDOW_LEN-1] = x;
		hist_y[WINDOW_LEN-1] = y;
		z = '0;
		if (filled < WINDOW_LEN - 1) begin
			filled++;
			return 1'b0;
		end
		sx = 0;
		sy = 0;
		for (i = 0; i < WINDOW_LEN; i++) begin
			sx += hist_x[i];
			sy += hist_y[i];
		end
		// integer division already truncates toward zero
		cx = sx / WINDOW_LEN;
		cy = sy / WINDOW_LEN;
		move = (last_cx > cx ? last_cx - cx : cx - last_cx)
			+ (last_cy > cy ? last_cy - cy : cy - last_cy);
		cw = crop_len(move, min_w, max_w);
		ch = crop_len(move, min_h, max_h);
		last_cx = cx;
		last_cy = cy;
		kx = cx - int'(cw / 2);
		ky = cy - int'(ch / 2);
		z.center_x    = cx[GAZE_W-1:0];
		z.center_y    = cy[GAZE_W-1:0];
		z.crop_width  = cw;
		z.crop_height = ch;
		z.corner_x    = kx[CORNER_W-1:0];
		z.corner_y    = ky[CORNER_W-1:0];
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		zoom_t want;
		zoom_t fresh;
		if (!arst_n) begin
			foreach (hist_x[i]) begin
				hist_x[i] = '0;
				hist_y[i] = '0;
			end
			filled  = 0;
			last_cx = 0;
			last_cy = 0;
			min_w   = CROP_W'(gszc_pkg::MIN_CROP_W_RST);
			max_w   = CROP_W'(gszc_pkg::MAX_CROP_W_RST);
			min_h   = CROP_W'(gszc_pkg::MIN_CROP_H_RST);
			max_h   = CROP_W'(gszc_pkg::MAX_CROP_H_RST);
			zoom_expected_q.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (zoom_expected_q.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					want = zoom_expected_q.pop_front();
					check_field("center_x", want.center_x, result.center_x);
					check_field("center_y", want.center_y, result.center_y);
					check_field("crop_width", want.crop_width, result.crop_width);
					check_field("crop_height", want.crop_height, result.crop_height);
					check_field("corner_x", want.corner_x, result.corner_x);
					check_field("corner_y", want.corner_y, result.corner_y);
					checked++;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					gszc_pkg::CFG_MIN_CROP_WIDTH:  min_w = cfg.data;
					gszc_pkg::CFG_MAX_CROP_WIDTH:  max_w = cfg.data;
					gszc_pkg::CFG_MIN_CROP_HEIGHT: min_h = cfg.data;
					gszc_pkg::CFG_MAX_CROP_HEIGHT: max_h = cfg.data;
					default: ;
				endcase
			end
			if (gaze.valid && gaze.ready) begin
				if (smooth_gaze_step(gaze.gaze_x, gaze.gaze_y, fresh))
					zoom_expected_q = {zoom_expected_q, fresh};
			end
			pending = zoom_expected_q.size();
		end
	end

endmodule

@@ tb/gaze_smoothed_zoom_crop_top_tb.sv @@
`timescale 1ns / 100ps
module gaze_smoothed_zoom_crop_top_tb;

	localparam int GAZE_W      = gszc_pkg::GAZE_W;
	localparam int CROP_W      = gszc_pkg::CROP_W;
	localparam int CFG_IDX_W   = gszc_pkg::CFG_IDX_W;
	localparam int CROP_MAX    = gszc_pkg::CROP_MAX;
	localparam int GAZE_MIN    = -4096;
	localparam int GAZE_MAX    = 4095;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 108;
	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 200000;
	// anything past the last register is dropped by the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

	typedef struct packed {
		logic signed [GAZE_W-1:0] x;
		logic signed [GAZE_W-1:0] y;
	} gaze_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending, checked;
	int   cycles = 0;
	int   sent = 0;
	int   hold_reqs = 0;
	bit   gaps_on = 1'b1;

	gaze_pt_t sample_q [$];
	gaze_pt_t walk;

	gszc_gaze_if   gaze_ch ();
	gszc_cfg_if    cfg_ch ();
	gszc_result_if result_ch ();

	gaze_smoothed_zoom_crop_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.gaze   (gaze_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	gaze_zoom_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.gaze    (gaze_ch),
		.cfg     (cfg_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off each time one is requested
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 10);
			end
		end
	end

	function automatic logic signed [GAZE_W-1:0] clamp_gaze(input int v);
		if (v < GAZE_MIN)
			return GAZE_W'(GAZE_MIN);
		if (v > GAZE_MAX)
			return GAZE_W'(GAZE_MAX);
		return GAZE_W'(v);
	endfunction

	// mostly a drifting gaze with small or large jumps, some full-range noise and edges
	function automatic gaze_pt_t pick_gaze(input gaze_pt_t prev);
		gaze_pt_t p;
		int kind, step;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			p.x = GAZE_W'($urandom);
			p.y = GAZE_W'($urandom);
		end else if (kind == 2) begin
			p.x = GAZE_W'($urandom_range(0, 1) ? GAZE_MAX : GAZE_MIN);
			p.y = GAZE_W'($urandom_range(0, 1) ? GAZE_MAX : GAZE_MIN);
		end else begin
			step = (kind < 7) ? 40 : 400;
			p.x = clamp_gaze(prev.x + int'($urandom_range(0, 2 * step)) - step);
			p.y = clamp_gaze(prev.y + int'($urandom_range(0, 2 * step)) - step);
		end
		return p;
	endfunction

	function automatic void queue_sample(input logic signed [GAZE_W-1:0] x,
			input logic signed [GAZE_W-1:0] y);
		gaze_pt_t p;
		p.x = x;
		p.y = y;
		sample_q = {sample_q, p};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CROP_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_crop(input logic [CROP_W-1:0] mn_w, input logic [CROP_W-1:0] mx_w,
			input logic [CROP_W-1:0] mn_h, input logic [CROP_W-1:0] mx_h);
		write_reg(gszc_pkg::CFG_MIN_CROP_WIDTH, mn_w);
		write_reg(gszc_pkg::CFG_MAX_CROP_WIDTH, mx_w);
		write_reg(gszc_pkg::CFG_MIN_CROP_HEIGHT, mn_h);
		write_reg(gszc_pkg::CFG_MAX_CROP_HEIGHT, mx_h);
	endtask

	task automatic send_samples();
		while (sample_q.size() > 0) begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 99) < 10) begin
				gaze_ch.valid <= 1'b0;
			end else begin
				gaze_ch.valid  <= 1'b1;
				gaze_ch.gaze_x <= sample_q[0].x;
				gaze_ch.gaze_y <= sample_q[0].y;
				do @(posedge clk); while (!gaze_ch.ready);
				void'(sample_q.pop_front());
				sent++;
			end
		end
		@(negedge clk);
		gaze_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [CROP_W-1:0] pick_size();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CROP_W'(CROP_MAX);
			default: return CROP_W'($urandom_range(0, CROP_MAX));
		endcase
	endfunction

	initial begin
		gaze_ch.valid  = 1'b0;
		gaze_ch.gaze_x = '0;
		gaze_ch.gaze_y = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default sizes, first result measured from the origin, extremes
		repeat (10) queue_sample(GAZE_W'(GAZE_MIN), GAZE_W'(GAZE_MIN));
		repeat (4) queue_sample(GAZE_W'(GAZE_MAX), GAZE_W'(GAZE_MAX));
		queue_sample(GAZE_W'(GAZE_MAX), GAZE_W'(GAZE_MIN));
		queue_sample(GAZE_W'(GAZE_MIN), GAZE_W'(GAZE_MAX));
		repeat (3) queue_sample(-13'sd1, 13'sd1);
		queue_sample(13'sd0, 13'sd0);
		queue_sample(13'sd7, -13'sd7);
		send_samples();
		drain();

		walk = '0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				// min above max: size saturates; min below max: size floors at zero
				0: write_crop(12'd1, CROP_W'(CROP_MAX), CROP_W'(CROP_MAX), 12'd1);
				1: write_crop('0, '0, CROP_W'(CROP_MAX), CROP_W'(CROP_MAX));
				default: write_crop(pick_size(), pick_size(), pick_size(), pick_size());
			endcase
			if (ph == 1)
				write_reg(CFG_SPARE_IDX, CROP_W'($urandom));
			gaps_on = (ph != 2);
			if (ph == 3) begin
				@(posedge clk);
				hold_reqs++;
			end
			repeat (PHASE_ITEMS) begin
				walk = pick_gaze(walk);
				queue_sample(walk.x, walk.y);
			end
			send_samples();
			drain();
		end

		$display("sent %0d gaze samples through default, extreme, zero and %0d random crop sets",
			sent, RAND_PHASES - 2);
		$display("compared %0d zoom results, including one long output hold-off", checked);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/gszc_pkg.sv
design/gszc_gaze_if.sv
design/gszc_result_if.sv
design/gszc_cfg_if.sv
design/gaze_smoothed_zoom_crop_top.sv
tb/gaze_zoom_checker.sv
tb/gaze_smoothed_zoom_crop_top_tb.sv
